/* rtl/rsrt_pkg.sv */
package rsrt_pkg;

   // Window and field sizes
   localparam int SEQ_MAX  = 32;
   localparam int IDX_W    = $clog2(SEQ_MAX);
   localparam int SEQ_W    = $clog2(SEQ_MAX + 1);
   localparam int HALF_WIN = SEQ_MAX / 2;
   localparam int CODE_W   = 16;

   // Register indexes on the csr port
   localparam logic CSR_NAK  = 1'b0;
   localparam logic CSR_PING = 1'b1;

   typedef enum logic [2:0] {
      KIND_DELIVER = 3'd0,
      KIND_DUP     = 3'd1,
      KIND_PING    = 3'd2,
      KIND_RESEND  = 3'd3,
      KIND_NAK     = 3'd4,
      KIND_BAD     = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_WALK,
      ST_CHECK,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // Bitmap write command, one entry per cycle
   typedef struct packed {
      logic             wr_en;
      logic             wr_bit;
      logic [IDX_W-1:0] idx;
   } map_cmd_type;

   // Bitmap status seen by the sequencer
   typedef struct packed {
      logic bit_at;
      logic any_set;
      logic any_above;
   } map_stat_type;

   // One result item
   typedef struct packed {
      kind_type          kind;
      logic [CODE_W-1:0] number;
      logic              last;
   } rsp_type;

   // Half-window serial comparison: is no newer than lr
   function automatic logic is_newer(input logic [SEQ_W-1:0] no, input logic [SEQ_W-1:0] lr);
      logic newer;
      newer = 1'b0;
      if (no > lr && (no - lr) <= SEQ_W'(HALF_WIN))
         newer = 1'b1;
      if (no < lr && (lr - no) > SEQ_W'(HALF_WIN))
         newer = 1'b1;
      return newer;
   endfunction

   // Bitmap index of the number after n (wraps from SEQ_MAX to 1)
   function automatic logic [IDX_W-1:0] idx_after(input logic [SEQ_W-1:0] n);
      logic [IDX_W-1:0] r;
      if (n == SEQ_W'(SEQ_MAX))
         r = '0;
      else
         r = n[IDX_W-1:0];
      return r;
   endfunction

endpackage

/* rtl/rsrt_map.sv */
module rsrt_map (
   input  logic                  clock,
   input  logic                  reset,
   input  rsrt_pkg::map_cmd_type map_cmd,
   output rsrt_pkg::map_stat_type map_stat
);
   import rsrt_pkg::*;

   logic [SEQ_MAX-1:0] map_ff;
   logic [SEQ_MAX-1:0] map_in;
   logic [SEQ_MAX-1:0] shifted;

   // Single-entry update at the shared index
   always_comb begin
      map_in = map_ff;
      if (map_cmd.wr_en)
         map_in[map_cmd.idx] = map_cmd.wr_bit;
   end

   always_ff @(posedge clock) begin
      if (reset)
         map_ff <= '0;
      else
         map_ff <= map_in;
   end

   // Status: entry at index, any entry set, any set above index
   assign shifted            = map_ff >> map_cmd.idx;
   assign map_stat.bit_at    = map_ff[map_cmd.idx];
   assign map_stat.any_set   = |map_ff;
   assign map_stat.any_above = |shifted[SEQ_MAX-1:1];

endmodule

/* rtl/rsrt_out.sv */
module rsrt_out (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  rsrt_pkg::rsp_type             load_data,
   output logic                          free,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_kind,
   output logic [rsrt_pkg::CODE_W-1:0]   rsp_number,
   output logic                          rsp_last
);
   import rsrt_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // Slot can take a new result when empty or being drained this cycle
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load)
         valid_in = 1'b1;
      else if (rsp_ready)
         valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load)
         data_ff <= load_data;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_kind   = data_ff.kind;
   assign rsp_number = data_ff.number;
   assign rsp_last   = data_ff.last;

endmodule

/* rtl/reliable_seq_receive_tracker_unit.sv */
// A resend, unreliable, malformed or stale ping packet and a tick with nothing missing go
// straight to the result slot; a newer reliable number or ping first walks the bitmap,
// marking skipped numbers missing (at most SEQ_MAX / 2), an older reliable number is checked
// against the bitmap, and a tick scans it, one NAK per missing number in ascending order.
// One item at a time: a new request is taken only after the last result loads.
// Reset (synchronous, active high): bitmap, last number cleared, codes 65535/65534.
module reliable_seq_receive_tracker_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_mode,
   input  logic [rsrt_pkg::CODE_W-1:0] req_trailer_code,
   input  logic [rsrt_pkg::CODE_W-1:0] req_lead_number,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [2:0]                  rsp_kind,
   output logic [rsrt_pkg::CODE_W-1:0] rsp_number,
   output logic                        rsp_last,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [rsrt_pkg::CODE_W-1:0] csr_wdata
);
   import rsrt_pkg::*;

   state_type         state_ff, state_in;
   logic [CODE_W-1:0] nak_code_ff, ping_code_ff;
   logic [SEQ_W-1:0]  last_rx_ff, last_rx_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  stop_ff, stop_in;
   logic [SEQ_W-1:0]  target_ff, target_in;
   logic              ping_ff, ping_in;
   rsp_type           res_ff, res_in;
   logic              mode_ff;
   logic [CODE_W-1:0] code_ff, lead_ff;

   map_cmd_type       map_cmd;
   map_stat_type      map_stat;
   logic              out_load, out_free;
   rsp_type           out_data;

   logic [IDX_W-1:0]  idx_next;
   logic [SEQ_W-1:0]  code_s, lead_s;

   // Shared index step, wrapping over the bitmap
   assign idx_next = (idx_ff == IDX_W'(SEQ_MAX - 1)) ? '0 : idx_ff + IDX_W'(1);
   assign code_s   = code_ff[SEQ_W-1:0];
   assign lead_s   = lead_ff[SEQ_W-1:0];

   assign req_ready = (state_ff == ST_IDLE);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nak_code_ff  <= 16'hFFFF;
         ping_code_ff <= 16'hFFFE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NAK:  nak_code_ff  <= csr_wdata;
            CSR_PING: ping_code_ff <= csr_wdata;
         endcase
      end
   end

   // Sequencer: next state and outputs
   always_comb begin
      state_in   = state_ff;
      last_rx_in = last_rx_ff;
      idx_in     = idx_ff;
      stop_in    = stop_ff;
      target_in  = target_ff;
      ping_in    = ping_ff;
      res_in     = res_ff;
      map_cmd    = '{wr_en: 1'b0, wr_bit: 1'b0, idx: idx_ff};
      out_load   = 1'b0;
      out_data   = res_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid)
               state_in = ST_DECODE;
         end

         ST_DECODE: begin
            res_in.last = 1'b1;
            state_in    = ST_EMIT;
            if (mode_ff) begin
               // tick: scan when something is missing
               res_in.kind   = KIND_BAD;
               res_in.number = '0;
               if (map_stat.any_set) begin
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end
            end else if (code_ff == nak_code_ff) begin
               if (lead_ff == '0 || lead_ff > CODE_W'(SEQ_MAX)) begin
                  res_in.kind   = KIND_BAD;
                  res_in.number = '0;
               end else begin
                  res_in.kind   = KIND_RESEND;
                  res_in.number = lead_ff;
               end
            end else if (code_ff == '0) begin
               // unreliable packet
               res_in.kind   = KIND_DELIVER;
               res_in.number = '0;
            end else if (code_ff == ping_code_ff) begin
               if (lead_ff > CODE_W'(SEQ_MAX)) begin
                  res_in.kind   = KIND_BAD;
                  res_in.number = '0;
               end else begin
                  res_in.kind   = KIND_PING;
                  res_in.number = lead_ff;
                  if (is_newer(lead_s, last_rx_ff)) begin
                     idx_in    = idx_after(last_rx_ff);
                     stop_in   = idx_after(lead_s);
                     target_in = lead_s;
                     ping_in   = 1'b1;
                     state_in  = ST_WALK;
                  end
               end
            end else if (code_ff > CODE_W'(SEQ_MAX)) begin
               res_in.kind   = KIND_BAD;
               res_in.number = '0;
            end else begin
               res_in.kind   = KIND_DELIVER;
               res_in.number = code_ff;
               if (is_newer(code_s, last_rx_ff)) begin
                  idx_in    = idx_after(last_rx_ff);
                  stop_in   = IDX_W'(code_s - SEQ_W'(1));
                  target_in = code_s;
                  ping_in   = 1'b0;
                  state_in  = ST_WALK;
               end else begin
                  idx_in   = IDX_W'(code_s - SEQ_W'(1));
                  state_in = ST_CHECK;
               end
            end
         end

         ST_WALK: begin
            // mark skipped numbers one per cycle
            if (idx_ff == stop_ff) begin
               last_rx_in = target_ff;
               if (!ping_ff) begin
                  map_cmd.wr_en  = 1'b1;
                  map_cmd.wr_bit = 1'b0;
               end
               state_in = ST_EMIT;
            end else begin
               map_cmd.wr_en  = 1'b1;
               map_cmd.wr_bit = 1'b1;
               idx_in         = idx_next;
            end
         end

         ST_CHECK: begin
            // old number: deliver only if it was missing
            if (!map_stat.bit_at) begin
               res_in.kind = KIND_DUP;
            end else begin
               map_cmd.wr_en  = 1'b1;
               map_cmd.wr_bit = 1'b0;
            end
            state_in = ST_EMIT;
         end

         ST_SCAN: begin
            if (map_stat.bit_at) begin
               if (out_free) begin
                  out_load        = 1'b1;
                  out_data.kind   = KIND_NAK;
                  out_data.number = CODE_W'(SEQ_W'(idx_ff) + SEQ_W'(1));
                  out_data.last   = !map_stat.any_above;
                  if (!map_stat.any_above)
                     state_in = ST_IDLE;
                  else
                     idx_in = idx_next;
               end
            end else begin
               idx_in = idx_next;
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         last_rx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         last_rx_ff <= last_rx_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      stop_ff   <= stop_in;
      target_ff <= target_in;
      ping_ff   <= ping_in;
      res_ff    <= res_in;
   end

   // Input capture on transfer
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff <= req_mode;
         code_ff <= req_trailer_code;
         lead_ff <= req_lead_number;
      end
   end

   rsrt_map u_map (
      .clock    (clock),
      .reset    (reset),
      .map_cmd  (map_cmd),
      .map_stat (map_stat)
   );

   rsrt_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .load_data  (out_data),
      .free       (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_kind   (rsp_kind),
      .rsp_number (rsp_number),
      .rsp_last   (rsp_last)
   );

endmodule
